>>> rtl/core/irpd_pkg.sv
// shared types and constants of the ir pulse distance decoder
// no dependencies; used by every module under rtl/core
package irpd_pkg;

  localparam int CFG_W      = 24;
  localparam int CFG_NUM    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAME_BITS = 16;
  localparam int COUNT_W    = 5;
  localparam int COUNT_SAT  = FRAME_BITS + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_START_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX = 3'd7;

  typedef logic [CFG_W-1:0] cfg_word_t;

  localparam cfg_word_t CFG_RESET [CFG_NUM] = '{
    24'(24000 * 3), 24'(28000 * 3), 24'(6000 * 3), 24'(8000 * 3),
    24'(10000 * 3), 24'(14000 * 3), 24'(600 * 3), 24'(2000 * 3)
  };

  localparam logic [1:0] KIND_EDGE     = 2'd0;
  localparam logic [1:0] KIND_PULSE_TO = 2'd1;
  localparam logic [1:0] KIND_SPACE_TO = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  localparam logic [1:0] ARM_STOP  = 2'd0;
  localparam logic [1:0] ARM_PULSE = 2'd1;
  localparam logic [1:0] ARM_SPACE = 2'd2;

  localparam logic [5:0] MODE_SAT  = 6'd63;
  localparam logic [5:0] CMD_POWER = 6'd61;

  typedef struct packed {
    logic start_ok;
    logic zero_ok;
    logic one_ok;
    logic pulse_ok;
  } width_class_t;

  typedef struct packed {
    logic       frame_valid;
    logic [5:0] command;
    logic [3:0] address;
    logic [5:0] mode;
    logic       power_key;
    logic [1:0] timeout_arm;
  } result_t;

endpackage

>>> rtl/core/irpd_cfg.sv
// window configuration registers of the ir pulse distance decoder
// depends on irpd_pkg
module irpd_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  logic [irpd_pkg::CFG_IDX_W-1:0]       wr_index,
  input  irpd_pkg::cfg_word_t                  wr_data,
  output irpd_pkg::cfg_word_t                  cfg_o [irpd_pkg::CFG_NUM]
);

  irpd_pkg::cfg_word_t cfg_r [irpd_pkg::CFG_NUM];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= irpd_pkg::CFG_RESET;
    end else if (wr_en) begin
      cfg_r[wr_index] <= wr_data;
    end
  end

  assign cfg_o = cfg_r;

endmodule

>>> rtl/core/irpd_classify.sv
// width measurement and window checks for one edge
// depends on irpd_pkg
module irpd_classify #(
  parameter int TIME_BITS = 24
) (
  input  logic [TIME_BITS-1:0]  timestamp,
  input  logic [TIME_BITS-1:0]  last_edge_time,
  input  irpd_pkg::cfg_word_t   cfg_i [irpd_pkg::CFG_NUM],
  output irpd_pkg::width_class_t cls
);

  localparam int CMP_W = (TIME_BITS > irpd_pkg::CFG_W) ? TIME_BITS : irpd_pkg::CFG_W;

  logic [TIME_BITS-1:0] width;
  logic [CMP_W-1:0]     width_x;
  logic [CMP_W-1:0]     lim_x [irpd_pkg::CFG_NUM];

  // modular difference
  assign width   = timestamp - last_edge_time;
  assign width_x = CMP_W'(width);

  always_comb begin
    for (int i = 0; i < irpd_pkg::CFG_NUM; i++) begin
      lim_x[i] = CMP_W'(cfg_i[i]);
    end
  end

  assign cls.start_ok = (width_x >= lim_x[irpd_pkg::CFG_START_MIN]) &&
                        (width_x <= lim_x[irpd_pkg::CFG_START_MAX]);
  assign cls.zero_ok  = (width_x >= lim_x[irpd_pkg::CFG_ZERO_MIN]) &&
                        (width_x <= lim_x[irpd_pkg::CFG_ZERO_MAX]);
  assign cls.one_ok   = (width_x >= lim_x[irpd_pkg::CFG_ONE_MIN]) &&
                        (width_x <= lim_x[irpd_pkg::CFG_ONE_MAX]);
  assign cls.pulse_ok = (width_x >= lim_x[irpd_pkg::CFG_PULSE_MIN]) &&
                        (width_x <= lim_x[irpd_pkg::CFG_PULSE_MAX]);

endmodule

>>> rtl/core/irpd_fsm.sv
// decoder state, frame assembly and result register
// depends on irpd_pkg
module irpd_fsm #(
  parameter int TIME_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_fire,
  input  logic [1:0]             kind,
  input  logic                   pin_level,
  input  logic [TIME_BITS-1:0]   timestamp,
  input  irpd_pkg::width_class_t cls,
  input  logic                   out_ready,
  output logic [TIME_BITS-1:0]   last_edge_time,
  output logic                   out_valid,
  output irpd_pkg::result_t      result
);

  typedef enum logic [1:0] {
    WAVE_IDLE  = 2'd0,
    WAVE_PULSE = 2'd1,
    WAVE_SPACE = 2'd2
  } wave_t;

  typedef enum logic [1:0] {
    FR_IDLE  = 2'd0,
    FR_START = 2'd1,
    FR_RECV  = 2'd2
  } frame_t;

  wave_t                             wave_r,  wave_nxt;
  frame_t                            frame_r, frame_nxt;
  logic [irpd_pkg::COUNT_W-1:0]      count_r, count_nxt;
  logic [irpd_pkg::FRAME_BITS-1:0]   shift_r, shift_nxt;
  logic [TIME_BITS-1:0]              last_r,  last_nxt;
  logic                              lock_r,  lock_nxt;
  logic                              out_valid_r;
  irpd_pkg::result_t                 res_r,   res_nxt;
  irpd_pkg::result_t                 frame_res;
  logic                              full;

  assign full = (count_r == irpd_pkg::COUNT_W'(irpd_pkg::FRAME_BITS));

  always_comb begin
    frame_res             = '0;
    frame_res.frame_valid = 1'b1;
    frame_res.command     = shift_r[15:10];
    frame_res.address     = shift_r[9:6];
    frame_res.mode        = shift_r[5:0];
    frame_res.power_key   = (shift_r[5:0] == irpd_pkg::MODE_SAT) &&
                            (shift_r[15:10] == irpd_pkg::CMD_POWER);
  end

  always_comb begin
    wave_nxt  = wave_r;
    frame_nxt = frame_r;
    count_nxt = count_r;
    shift_nxt = shift_r;
    last_nxt  = last_r;
    lock_nxt  = lock_r;
    res_nxt   = '0;

    unique case (kind)
      irpd_pkg::KIND_NONE: begin
      end
      irpd_pkg::KIND_PULSE_TO: begin
        wave_nxt  = WAVE_IDLE;
        frame_nxt = FR_IDLE;
        count_nxt = '0;
        shift_nxt = '0;
        last_nxt  = '0;
        lock_nxt  = 1'b0;
      end
      irpd_pkg::KIND_SPACE_TO: begin
        if (full && !lock_r) begin
          res_nxt = frame_res;
        end
        wave_nxt  = WAVE_IDLE;
        frame_nxt = FR_IDLE;
        count_nxt = '0;
        shift_nxt = '0;
        last_nxt  = '0;
        lock_nxt  = 1'b0;
      end
      irpd_pkg::KIND_EDGE: begin
        // default outcome of any bad edge: discard
        wave_nxt  = WAVE_IDLE;
        frame_nxt = FR_IDLE;
        count_nxt = '0;
        shift_nxt = '0;
        last_nxt  = '0;
        lock_nxt  = 1'b0;
        if (lock_r) begin
          wave_nxt  = wave_r;
          frame_nxt = frame_r;
          count_nxt = count_r;
          shift_nxt = shift_r;
          last_nxt  = last_r;
          lock_nxt  = lock_r;
          res_nxt.timeout_arm = pin_level ? irpd_pkg::ARM_SPACE : irpd_pkg::ARM_PULSE;
        end else if (!pin_level) begin
          // mark begins
          if (wave_r == WAVE_IDLE) begin
            last_nxt  = timestamp;
            wave_nxt  = WAVE_PULSE;
            frame_nxt = FR_START;
            res_nxt.timeout_arm = irpd_pkg::ARM_PULSE;
          end else if (wave_r == WAVE_SPACE && frame_r == FR_START) begin
            if (cls.start_ok) begin
              frame_nxt = FR_RECV;
              count_nxt = count_r;
              shift_nxt = shift_r;
            end
            last_nxt = timestamp;
            wave_nxt = WAVE_PULSE;
            res_nxt.timeout_arm = irpd_pkg::ARM_PULSE;
          end else if (wave_r == WAVE_SPACE && frame_r == FR_RECV) begin
            if (cls.zero_ok || cls.one_ok) begin
              frame_nxt = frame_r;
              shift_nxt = {shift_r[irpd_pkg::FRAME_BITS-2:0], !cls.zero_ok};
              count_nxt = (count_r < irpd_pkg::COUNT_W'(irpd_pkg::COUNT_SAT)) ?
                          count_r + 1'b1 : count_r;
              last_nxt  = timestamp;
              wave_nxt  = WAVE_PULSE;
              res_nxt.timeout_arm = irpd_pkg::ARM_PULSE;
            end else if (cls.start_ok) begin
              if (full) begin
                res_nxt  = frame_res;
                lock_nxt = 1'b1;
              end else begin
                lock_nxt = lock_r;
              end
              frame_nxt = FR_RECV;
              wave_nxt  = WAVE_PULSE;
              last_nxt  = timestamp;
              res_nxt.timeout_arm = irpd_pkg::ARM_PULSE;
            end
          end
        end else begin
          // mark ends
          if (wave_r == WAVE_PULSE && cls.pulse_ok) begin
            wave_nxt  = WAVE_SPACE;
            frame_nxt = frame_r;
            count_nxt = count_r;
            shift_nxt = shift_r;
            last_nxt  = timestamp;
            res_nxt.timeout_arm = irpd_pkg::ARM_SPACE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r      <= WAVE_IDLE;
      frame_r     <= FR_IDLE;
      count_r     <= '0;
      shift_r     <= '0;
      last_r      <= '0;
      lock_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      wave_r      <= wave_nxt;
      frame_r     <= frame_nxt;
      count_r     <= count_nxt;
      shift_r     <= shift_nxt;
      last_r      <= last_nxt;
      lock_r      <= lock_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign last_edge_time = last_r;
  assign out_valid      = out_valid_r;
  assign result         = res_r;

endmodule

>>> rtl/core/ir_pulse_distance_decoder_core.sv
// Pulse-distance IR remote decoder: takes pin edges stamped with a free-running
// tick count plus pulse and space timeout events, and returns one result per item
// (a decoded 16-bit frame when one completes, and which timeout timer to arm).
// The width subtraction, the eight window compares and the state update sit
// between the decoder state and the result register, so an item is accepted each
// cycle while the result register is empty or being drained. The result is
// registered. The user is to write window registers through the cfg_ port only
// while the block is idle; the block does not enforce it. cfg_ready is always high.
// Depends on irpd_pkg, irpd_cfg, irpd_classify and irpd_fsm.
module ir_pulse_distance_decoder_core #(
  parameter int TIME_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_kind,
  input  logic                               in_pin_level,
  input  logic [TIME_BITS-1:0]               in_timestamp,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_frame_valid,
  output logic [5:0]                         out_command,
  output logic [3:0]                         out_address,
  output logic [5:0]                         out_mode,
  output logic                               out_power_key,
  output logic [1:0]                         out_timeout_arm,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [irpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [irpd_pkg::CFG_W-1:0]         cfg_data
);

  irpd_pkg::cfg_word_t    cfg_words [irpd_pkg::CFG_NUM];
  irpd_pkg::width_class_t cls;
  irpd_pkg::result_t      result;
  logic [TIME_BITS-1:0]   last_edge_time;
  logic                   in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  irpd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg_o    (cfg_words)
  );

  irpd_classify #(
    .TIME_BITS (TIME_BITS)
  ) u_classify (
    .timestamp      (in_timestamp),
    .last_edge_time (last_edge_time),
    .cfg_i          (cfg_words),
    .cls            (cls)
  );

  irpd_fsm #(
    .TIME_BITS (TIME_BITS)
  ) u_fsm (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .kind           (in_kind),
    .pin_level      (in_pin_level),
    .timestamp      (in_timestamp),
    .cls            (cls),
    .out_ready      (out_ready),
    .last_edge_time (last_edge_time),
    .out_valid      (out_valid),
    .result         (result)
  );

  assign out_frame_valid = result.frame_valid;
  assign out_command     = result.command;
  assign out_address     = result.address;
  assign out_mode        = result.mode;
  assign out_power_key   = result.power_key;
  assign out_timeout_arm = result.timeout_arm;

endmodule
